/* design/lbvc_pkg.sv */
package lbvc_pkg;

	// fixed widths of the data path
	localparam int SIG_W         = 32;
	localparam int FRACTION_BITS = 16;
	localparam int GAIN_FRAC     = 16;
	localparam int STEP_FRAC     = 32;
	localparam int LIM_W         = 31;
	localparam int MUL_W         = SIG_W + 1;
	localparam int PROD_W        = 2 * MUL_W;
	localparam int TERM_W        = PROD_W - GAIN_FRAC;
	localparam int ACC_W         = TERM_W + 2;
	localparam int DELTA_W       = PROD_W - STEP_FRAC;
	localparam int TICK_W        = 13;
	localparam int SETTLE_W      = 10;
	localparam int CFG_ADDR_W    = 5;
	localparam int CFG_DATA_W    = 32;

	// schedule and deadband levels in the signal format
	localparam longint ONE_Q = longint'(1) << FRACTION_BITS;
	localparam logic signed [SIG_W-1:0] TARGET_POS  = SIG_W'((8 * ONE_Q + 50) / 100);
	localparam logic signed [SIG_W-1:0] TARGET_NEG  = SIG_W'(-((12 * ONE_Q + 50) / 100));
	localparam logic signed [SIG_W-1:0] SWITCH_HI   = SIG_W'((36 * ONE_Q + 500) / 1000);
	localparam logic signed [SIG_W-1:0] SWITCH_LO   = SIG_W'(-((48 * ONE_Q + 500) / 1000));
	localparam logic signed [SIG_W-1:0] DEAD_VEL    = SIG_W'((ONE_Q + 5000) / 10000);
	localparam logic signed [SIG_W-1:0] DEAD_VEL_N  = SIG_W'(-((ONE_Q + 5000) / 10000));
	localparam logic signed [SIG_W-1:0] DEAD_ANG    = SIG_W'((5 * ONE_Q + 500) / 1000);
	localparam logic signed [SIG_W-1:0] DEAD_ANG_N  = SIG_W'(-((5 * ONE_Q + 500) / 1000));

	// soft gains, integers held in the gain format
	localparam logic signed [SIG_W-1:0] SOFT_POS  = SIG_W'(longint'(100) << GAIN_FRAC);
	localparam logic signed [SIG_W-1:0] SOFT_VEL  = SIG_W'(longint'(54) << GAIN_FRAC);
	localparam logic signed [SIG_W-1:0] SOFT_ANG  = SIG_W'(longint'(274) << GAIN_FRAC);
	localparam logic signed [SIG_W-1:0] SOFT_RATE = SIG_W'(longint'(36) << GAIN_FRAC);

	localparam logic [TICK_W-1:0]   START_TICK   = TICK_W'(250);
	localparam logic [TICK_W-1:0]   MOVE_TICK    = TICK_W'(4000);
	localparam logic [SETTLE_W-1:0] SETTLE_TICKS = SETTLE_W'(500);

	// register reset values
	localparam logic [31:0] RST_GAIN_POS  = 32'd5832704;
	localparam logic [31:0] RST_GAIN_VEL  = 32'd6356992;
	localparam logic [31:0] RST_GAIN_ANG  = 32'd23658496;
	localparam logic [31:0] RST_GAIN_RATE = 32'd2621440;
	localparam logic [30:0] RST_FORCE_LIM = 31'h7fffffff;
	localparam logic [30:0] RST_VEL_LIM   = 31'h7fffffff;
	localparam logic [31:0] RST_STEP_NORM = 32'd4294967;
	localparam logic [31:0] RST_STEP_SOFT = 32'd879706;

	typedef enum logic [2:0] {
		REG_GAIN_POS,
		REG_GAIN_VEL,
		REG_GAIN_ANG,
		REG_GAIN_RATE,
		REG_FORCE_LIM,
		REG_VEL_LIM,
		REG_STEP_NORM,
		REG_STEP_SOFT
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_HOLD,
		MODE_ZERO,
		MODE_POS,
		MODE_NEG
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_TERM,
		ST_FORCE,
		ST_STEP,
		ST_VEL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [SIG_W-1:0] gain_position;
		logic signed [SIG_W-1:0] gain_velocity;
		logic signed [SIG_W-1:0] gain_angle;
		logic signed [SIG_W-1:0] gain_angle_rate;
		logic [LIM_W-1:0]        force_limit;
		logic [LIM_W-1:0]        velocity_limit;
		logic [SIG_W-1:0]        step_gain_normal;
		logic [SIG_W-1:0]        step_gain_soft;
	} cfg_t;

	typedef struct packed {
		logic signed [SIG_W-1:0] cart_position;
		logic signed [SIG_W-1:0] cart_velocity;
		logic signed [SIG_W-1:0] pole_angle;
		logic signed [SIG_W-1:0] pole_angle_rate;
	} meas_t;

	typedef struct packed {
		logic signed [SIG_W-1:0] velocity_command;
		logic signed [SIG_W-1:0] force_command;
		logic signed [SIG_W-1:0] target_position;
		logic [1:0]              target_mode;
		logic                    soft_phase;
	} cmd_t;

endpackage

/* design/lbvc_if.sv */
// measurement beat channel
interface lbvc_meas_if import lbvc_pkg::*; ();
	logic  valid;
	logic  ready;
	meas_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// command beat channel
interface lbvc_cmd_if import lbvc_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/lqr_balance_velocity_controller_top.sv */
// channel   | dir | handshake          | payload
// meas      | in  | valid/ready        | cart_position, cart_velocity, pole_angle,
//           |     |                    | pole_angle_rate
// cmd       | out | valid/ready        | velocity_command, force_command,
//           |     |                    | target_position, target_mode, soft_phase
// apb       | in  | psel/penable/pready| eight registers at byte address 4*i
//
// no new measurement is taken until the last is through: ready drops on acceptance
// and stays low through prepare, five multiply and add steps, force clamp,
// velocity step, velocity clamp and hand-off, where the result is registered.
// a single 33x33 multiplier with a registered product serves the four feedback
// terms and the force-to-velocity step in turn.
// reset clears the schedule, the settle count and the velocity accumulator.
// a finished result sits in the output register; the block goes back to ready
// while it waits, and stalls before a second result only if the first is unread.
module lqr_balance_velocity_controller_top import lbvc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	lbvc_meas_if.sink             meas,
	lbvc_cmd_if.source            cmd,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam logic [2:0] TERM_POS  = 3'd0;
	localparam logic [2:0] TERM_VEL  = 3'd1;
	localparam logic [2:0] TERM_ANG  = 3'd2;
	localparam logic [2:0] TERM_RATE = 3'd3;
	localparam logic [2:0] TERM_LAST = 3'd4;

	cfg_t cfg;

	lbvc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	state_t state_q, state_nxt;
	logic [2:0] cnt_q;

	// long-lived state
	logic [TICK_W-1:0]   ticks_q, ticks_nxt;
	mode_t               mode_q, mode_nxt;
	logic [SETTLE_W-1:0] settle_q, settle_nxt;
	logic signed [SIG_W-1:0] vacc_q;

	// per-item payload
	logic signed [SIG_W-1:0]  x_q, v_q, th_q, thd_q, target_q, target_nxt, err_q, force_q;
	logic                     soft_q, step_soft_q, v_pass_q, a_pass_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  sum_q;

	cmd_t out_q;
	logic out_valid_q;

	// control decoded from state
	logic in_ready, out_free, out_load, mul_en, add_en, sel_step;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod, prod_rnd_term, prod_rnd_step;
	logic signed [TERM_W-1:0] term;
	logic signed [DELTA_W-1:0] delta;
	logic signed [SIG_W:0]    diff;
	logic signed [SIG_W-1:0]  err_sat;
	logic signed [ACC_W-1:0]  flim, force_cl;
	logic signed [SIG_W+2:0]  vsum, vlim, vel_cl;
	logic signed [SIG_W-1:0]  coef, sig;

	assign meas.ready = in_ready;
	assign cmd.valid  = out_valid_q;
	assign cmd.data   = out_q;
	assign out_free   = !out_valid_q || cmd.ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (meas.valid) state_nxt = ST_PREP;
			ST_PREP:  state_nxt = ST_TERM;
			ST_TERM:  if (cnt_q == TERM_LAST) state_nxt = ST_FORCE;
			ST_FORCE: state_nxt = ST_STEP;
			ST_STEP:  state_nxt = ST_VEL;
			ST_VEL:   state_nxt = ST_DONE;
			ST_DONE:  if (out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready = 1'b0;
		mul_en   = 1'b0;
		add_en   = 1'b0;
		sel_step = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_TERM: begin
				mul_en = (cnt_q != TERM_LAST);
				add_en = (cnt_q != TERM_POS);
			end
			ST_STEP: begin
				mul_en   = 1'b1;
				sel_step = 1'b1;
			end
			ST_DONE: out_load = out_free;
			default: ;
		endcase
	end

	// setpoint schedule on the incoming position
	always_comb begin
		ticks_nxt = ticks_q;
		mode_nxt  = mode_q;
		if (ticks_q < MOVE_TICK) ticks_nxt = ticks_q + 1'b1;
		if (ticks_nxt == START_TICK) mode_nxt = MODE_ZERO;
		if (ticks_nxt == MOVE_TICK) begin
			mode_nxt  = MODE_POS;
			ticks_nxt = ticks_nxt + 1'b1;
		end
		if (mode_nxt == MODE_POS && meas.data.cart_position >= SWITCH_HI) mode_nxt = MODE_NEG;
		if (mode_nxt == MODE_NEG && meas.data.cart_position <= SWITCH_LO) mode_nxt = MODE_POS;
		case (mode_nxt)
			MODE_HOLD: target_nxt = meas.data.cart_position;
			MODE_ZERO: target_nxt = '0;
			MODE_POS:  target_nxt = TARGET_POS;
			MODE_NEG:  target_nxt = TARGET_NEG;
			default:   target_nxt = '0;
		endcase
		settle_nxt = (settle_q < SETTLE_TICKS) ? settle_q + 1'b1 : settle_q;
	end

	// position error with saturation
	always_comb begin
		diff = {x_q[SIG_W-1], x_q} - {target_q[SIG_W-1], target_q};
		if (diff[SIG_W] != diff[SIG_W-1])
			err_sat = diff[SIG_W] ? {1'b1, {(SIG_W-1){1'b0}}} : {1'b0, {(SIG_W-1){1'b1}}};
		else
			err_sat = diff[SIG_W-1:0];
	end

	// shared multiplier operand select
	always_comb begin
		case (cnt_q)
			TERM_POS: begin
				coef = soft_q ? SOFT_POS : cfg.gain_position;
				sig  = err_q;
			end
			TERM_VEL: begin
				coef = soft_q ? SOFT_VEL : cfg.gain_velocity;
				sig  = (soft_q && !v_pass_q) ? '0 : v_q;
			end
			TERM_ANG: begin
				coef = soft_q ? SOFT_ANG : cfg.gain_angle;
				sig  = (soft_q && !a_pass_q) ? '0 : th_q;
			end
			TERM_RATE: begin
				coef = soft_q ? SOFT_RATE : cfg.gain_angle_rate;
				sig  = thd_q;
			end
			default: begin
				coef = '0;
				sig  = '0;
			end
		endcase
		if (sel_step) begin
			mul_a = {force_q[SIG_W-1], force_q};
			mul_b = {1'b0, step_soft_q ? cfg.step_gain_soft : cfg.step_gain_normal};
		end else begin
			mul_a = {coef[SIG_W-1], coef};
			mul_b = {sig[SIG_W-1], sig};
		end
		prod = mul_a * mul_b;
	end

	// rounding of the registered product and the clamps
	always_comb begin
		prod_rnd_term = prod_q + (PROD_W'(1) <<< (GAIN_FRAC - 1));
		prod_rnd_step = prod_q + (PROD_W'(1) <<< (STEP_FRAC - 1));
		term  = prod_rnd_term[PROD_W-1:GAIN_FRAC];
		delta = prod_rnd_step[PROD_W-1:STEP_FRAC];

		flim = ACC_W'({1'b0, cfg.force_limit});
		if (sum_q > flim) force_cl = flim;
		else if (sum_q < -flim) force_cl = -flim;
		else force_cl = sum_q;

		vlim = (SIG_W+3)'({1'b0, cfg.velocity_limit});
		vsum = (SIG_W+3)'(vacc_q) + (SIG_W+3)'(delta);
		if (vsum > vlim) vel_cl = vlim;
		else if (vsum < -vlim) vel_cl = -vlim;
		else vel_cl = vsum;
	end

	// control and long-lived state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= TERM_POS;
			ticks_q     <= '0;
			mode_q      <= MODE_HOLD;
			settle_q    <= '0;
			vacc_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_PREP) cnt_q <= TERM_POS;
			else if (state_q == ST_TERM) cnt_q <= cnt_q + 1'b1;
			if (meas.valid && in_ready) begin
				ticks_q  <= ticks_nxt;
				mode_q   <= mode_nxt;
				settle_q <= settle_nxt;
			end
			if (state_q == ST_VEL) vacc_q <= vel_cl[SIG_W-1:0];
			if (out_load) out_valid_q <= 1'b1;
			else if (cmd.ready) out_valid_q <= 1'b0;
		end
	end

	// data path registers
	always_ff @(posedge clk) begin
		if (meas.valid && in_ready) begin
			x_q         <= meas.data.cart_position;
			v_q         <= meas.data.cart_velocity;
			th_q        <= meas.data.pole_angle;
			thd_q       <= meas.data.pole_angle_rate;
			target_q    <= target_nxt;
			soft_q      <= (settle_q >= SETTLE_TICKS);
			step_soft_q <= (settle_nxt >= SETTLE_TICKS);
		end
		if (state_q == ST_PREP) begin
			err_q    <= err_sat;
			v_pass_q <= (v_q > DEAD_VEL) || (v_q < DEAD_VEL_N);
			a_pass_q <= (th_q > DEAD_ANG) || (th_q < DEAD_ANG_N);
			sum_q    <= '0;
		end else if (add_en) begin
			sum_q <= sum_q + ACC_W'(term);
		end
		if (mul_en) prod_q <= prod;
		if (state_q == ST_FORCE) force_q <= force_cl[SIG_W-1:0];
		if (out_load) begin
			out_q.velocity_command <= vacc_q;
			out_q.force_command    <= force_q;
			out_q.target_position  <= target_q;
			out_q.target_mode      <= mode_q;
			out_q.soft_phase       <= soft_q;
		end
	end

endmodule

/* design/lbvc_regs.sv */
module lbvc_regs import lbvc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_position    <= RST_GAIN_POS;
			cfg_q.gain_velocity    <= RST_GAIN_VEL;
			cfg_q.gain_angle       <= RST_GAIN_ANG;
			cfg_q.gain_angle_rate  <= RST_GAIN_RATE;
			cfg_q.force_limit      <= RST_FORCE_LIM;
			cfg_q.velocity_limit   <= RST_VEL_LIM;
			cfg_q.step_gain_normal <= RST_STEP_NORM;
			cfg_q.step_gain_soft   <= RST_STEP_SOFT;
		end else if (wr_en) begin
			case (idx)
				REG_GAIN_POS:  cfg_q.gain_position    <= pwdata;
				REG_GAIN_VEL:  cfg_q.gain_velocity    <= pwdata;
				REG_GAIN_ANG:  cfg_q.gain_angle       <= pwdata;
				REG_GAIN_RATE: cfg_q.gain_angle_rate  <= pwdata;
				REG_FORCE_LIM: cfg_q.force_limit      <= pwdata[LIM_W-1:0];
				REG_VEL_LIM:   cfg_q.velocity_limit   <= pwdata[LIM_W-1:0];
				REG_STEP_NORM: cfg_q.step_gain_normal <= pwdata;
				REG_STEP_SOFT: cfg_q.step_gain_soft   <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_GAIN_POS:  prdata = cfg_q.gain_position;
			REG_GAIN_VEL:  prdata = cfg_q.gain_velocity;
			REG_GAIN_ANG:  prdata = cfg_q.gain_angle;
			REG_GAIN_RATE: prdata = cfg_q.gain_angle_rate;
			REG_FORCE_LIM: prdata = {1'b0, cfg_q.force_limit};
			REG_VEL_LIM:   prdata = {1'b0, cfg_q.velocity_limit};
			REG_STEP_NORM: prdata = cfg_q.step_gain_normal;
			REG_STEP_SOFT: prdata = cfg_q.step_gain_soft;
			default:       prdata = '0;
		endcase
	end

endmodule
